/* sv/imhdk_pkg.sv */
// ----------------------------------------------------------------------------
// imhdk_pkg
// Shared codes and controller/datapath command and status types for the
// indexed min-heap with decrease-key.
// ----------------------------------------------------------------------------
`default_nettype none

package imhdk_pkg;

  // Field widths fixed by the item format
  localparam int unsigned NodeBits   = 12;
  localparam int unsigned InKeyBits  = 32;
  localparam int unsigned CountBits  = 11;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DECREASED = 3'd1,
    ST_UNCHANGED = 3'd2,
    ST_EXTRACTED = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  // Heap read address select
  typedef enum logic [2:0] {
    HR_ROOT   = 3'd0,
    HR_LAST   = 3'd1,
    HR_PARENT = 3'd2,
    HR_LEFT   = 3'd3,
    HR_RIGHT  = 3'd4,
    HR_POS    = 3'd5
  } heap_rd_e;

  // Heap write data select (always written at the current slot)
  typedef enum logic [1:0] {
    HW_NONE   = 2'd0,
    HW_MOVING = 2'd1,
    HW_RDATA  = 2'd2,
    HW_LEFT   = 2'd3
  } heap_wr_e;

  // Current slot update
  typedef enum logic [2:0] {
    IOP_HOLD   = 3'd0,
    IOP_FILL   = 3'd1,
    IOP_POS    = 3'd2,
    IOP_ZERO   = 3'd3,
    IOP_PARENT = 3'd4,
    IOP_LEFT   = 3'd5,
    IOP_RIGHT  = 3'd6
  } idx_op_e;

  typedef struct packed {
    logic     accept;
    heap_rd_e hrd;
    heap_wr_e hwr;
    idx_op_e  iop;
    logic     load_top;
    logic     load_mov_rd;
    logic     load_mov_in;
    logic     load_left;
    logic     fill_inc;
    logic     fill_dec;
    logic     pos_clr_top;
    logic     clear_step;
    logic     res_set;
    status_e  res_code;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_extract;
    logic in_oob;
    logic fill_zero;
    logic fill_full;
    logic fill_one;
    logic pos_valid;
    logic pos_slot_ge_fill;
    logic in_lt_rd;
    logic i_zero;
    logic mov_lt_rd;
    logic mov_gt_rd;
    logic mov_gt_left;
    logic left_lt_rd;
    logic l_ge_fill;
    logic r_ge_fill;
    logic clear_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* sv/imhdk_if.sv */
// ----------------------------------------------------------------------------
// imhdk_in_if / imhdk_out_if
// Valid/ready channels carrying request items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface imhdk_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [11:0] node_id;
  logic [31:0] cost_key;
  logic [11:0] neighbour_id;

  modport source (output valid, opcode, node_id, cost_key, neighbour_id, input ready);
  modport sink   (input valid, opcode, node_id, cost_key, neighbour_id, output ready);
endinterface

interface imhdk_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [11:0] out_node;
  logic [31:0] out_key;
  logic [11:0] out_neighbour;
  logic [10:0] entry_count;

  modport source (output valid, status, out_node, out_key, out_neighbour, entry_count,
                  input ready);
  modport sink   (input valid, status, out_node, out_key, out_neighbour, entry_count,
                  output ready);
endinterface

`default_nettype wire

/* sv/imhdk_ram.sv */
// ----------------------------------------------------------------------------
// imhdk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module imhdk_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* sv/imhdk_ctrl.sv */
// ----------------------------------------------------------------------------
// imhdk_ctrl
// Sequencer for the heap: position-table clear, insert, decrease-key,
// extract, sift up and sift down.
// ----------------------------------------------------------------------------
`default_nettype none

module imhdk_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire imhdk_pkg::sts_t sts_i,
  output imhdk_pkg::cmd_t     cmd_o,
  output logic                in_ready_o
);
  import imhdk_pkg::*;

  typedef enum logic [10:0] {
    S_CLEAR   = 11'b00000000001,
    S_IDLE    = 11'b00000000010,
    S_INS_POS = 11'b00000000100,
    S_DEC_RD  = 11'b00000001000,
    S_UP_CHK  = 11'b00000010000,
    S_UP_CMP  = 11'b00000100000,
    S_EX_ROOT = 11'b00001000000,
    S_EX_LAST = 11'b00010000000,
    S_DN_CHK  = 11'b00100000000,
    S_DN_L    = 11'b01000000000,
    S_DN_R    = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;   // result ready to be loaded into the output register

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE) && !done_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    done_d  = done_q;
    cmd_o   = '{accept: 1'b0, hrd: HR_ROOT, hwr: HW_NONE, iop: IOP_HOLD,
                load_top: 1'b0, load_mov_rd: 1'b0, load_mov_in: 1'b0,
                load_left: 1'b0, fill_inc: 1'b0, fill_dec: 1'b0,
                pos_clr_top: 1'b0, clear_step: 1'b0, res_set: 1'b0,
                res_code: ST_UNCHANGED, out_load: 1'b0};
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (done_q) begin
          if (sts_i.out_free) begin
            cmd_o.out_load = 1'b1;
            done_d         = 1'b0;
          end
        end else if (sts_i.in_valid) begin
          cmd_o.accept = 1'b1;
          if (sts_i.in_extract) begin
            if (sts_i.fill_zero) begin
              cmd_o.res_set  = 1'b1;
              cmd_o.res_code = ST_EMPTY;
              done_d         = 1'b1;
            end else begin
              cmd_o.hrd = HR_ROOT;
              state_d   = S_EX_ROOT;
            end
          end else if (sts_i.in_oob) begin
            cmd_o.res_set  = 1'b1;
            cmd_o.res_code = ST_UNCHANGED;
            done_d         = 1'b1;
          end else begin
            state_d = S_INS_POS;
          end
        end
      end
      S_INS_POS: begin
        cmd_o.res_set = 1'b1;
        if (!sts_i.pos_valid) begin
          if (sts_i.fill_full) begin
            cmd_o.res_code = ST_FULL;
            done_d         = 1'b1;
            state_d        = S_IDLE;
          end else begin
            cmd_o.res_code    = ST_INSERTED;
            cmd_o.iop         = IOP_FILL;
            cmd_o.fill_inc    = 1'b1;
            cmd_o.load_mov_in = 1'b1;
            state_d           = S_UP_CHK;
          end
        end else if (sts_i.pos_slot_ge_fill) begin
          cmd_o.res_code = ST_UNCHANGED;
          done_d         = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.res_set = 1'b0;
          cmd_o.hrd     = HR_POS;
          cmd_o.iop     = IOP_POS;
          state_d       = S_DEC_RD;
        end
      end
      S_DEC_RD: begin
        cmd_o.res_set = 1'b1;
        if (sts_i.in_lt_rd) begin
          cmd_o.res_code    = ST_DECREASED;
          cmd_o.load_mov_in = 1'b1;
          state_d           = S_UP_CHK;
        end else begin
          cmd_o.res_code = ST_UNCHANGED;
          done_d         = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_UP_CHK: begin
        if (sts_i.i_zero) begin
          cmd_o.hwr = HW_MOVING;
          done_d    = 1'b1;
          state_d   = S_IDLE;
        end else begin
          cmd_o.hrd = HR_PARENT;
          state_d   = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts_i.mov_lt_rd) begin
          cmd_o.hwr = HW_RDATA;
          cmd_o.iop = IOP_PARENT;
          state_d   = S_UP_CHK;
        end else begin
          cmd_o.hwr = HW_MOVING;
          done_d    = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_EX_ROOT: begin
        cmd_o.load_top = 1'b1;
        cmd_o.hrd      = HR_LAST;
        state_d        = S_EX_LAST;
      end
      S_EX_LAST: begin
        cmd_o.load_mov_rd = 1'b1;
        cmd_o.fill_dec    = 1'b1;
        cmd_o.pos_clr_top = 1'b1;
        cmd_o.res_set     = 1'b1;
        cmd_o.res_code    = ST_EXTRACTED;
        cmd_o.iop         = IOP_ZERO;
        if (sts_i.fill_one) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_DN_CHK;
        end
      end
      S_DN_CHK: begin
        if (sts_i.l_ge_fill) begin
          cmd_o.hwr = HW_MOVING;
          done_d    = 1'b1;
          state_d   = S_IDLE;
        end else begin
          cmd_o.hrd = HR_LEFT;
          state_d   = S_DN_L;
        end
      end
      S_DN_L: begin
        if (sts_i.r_ge_fill) begin
          if (sts_i.mov_gt_rd) begin
            cmd_o.hwr = HW_RDATA;
            cmd_o.iop = IOP_LEFT;
            state_d   = S_DN_CHK;
          end else begin
            cmd_o.hwr = HW_MOVING;
            done_d    = 1'b1;
            state_d   = S_IDLE;
          end
        end else begin
          cmd_o.load_left = 1'b1;
          cmd_o.hrd       = HR_RIGHT;
          state_d         = S_DN_R;
        end
      end
      S_DN_R: begin
        state_d = S_DN_CHK;
        if (sts_i.mov_gt_left || sts_i.mov_gt_rd) begin
          // ties between the children go right
          if (sts_i.left_lt_rd) begin
            cmd_o.hwr = HW_LEFT;
            cmd_o.iop = IOP_LEFT;
          end else begin
            cmd_o.hwr = HW_RDATA;
            cmd_o.iop = IOP_RIGHT;
          end
        end else begin
          cmd_o.hwr = HW_MOVING;
          done_d    = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/imhdk_dp.sv */
// ----------------------------------------------------------------------------
// imhdk_dp
// Heap datapath: heap slot RAM, position table RAM, moving entry, slot
// index, fill count, key compares and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module imhdk_dp #(
  parameter int unsigned HeapCapacity = 1024,
  parameter int unsigned NodeCount    = 4096,
  parameter int unsigned KeyBits      = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire imhdk_pkg::cmd_t cmd_i,
  output imhdk_pkg::sts_t      sts_o,
  // request payload
  input  wire logic            in_valid_i,
  input  wire logic            opcode_i,
  input  wire logic [11:0]     node_id_i,
  input  wire logic [31:0]     cost_key_i,
  input  wire logic [11:0]     neighbour_id_i,
  // result channel
  input  wire logic            out_ready_i,
  output logic                 out_valid_o,
  output logic [2:0]           status_o,
  output logic [11:0]          out_node_o,
  output logic [31:0]          out_key_o,
  output logic [11:0]          out_neighbour_o,
  output logic [10:0]          entry_count_o
);
  import imhdk_pkg::*;

  localparam int unsigned SW     = $clog2(HeapCapacity);
  localparam int unsigned CW     = $clog2(HeapCapacity + 1);
  localparam int unsigned NW     = $clog2(NodeCount);
  localparam int unsigned PW     = SW + 1;
  localparam int unsigned EW     = 2 * NodeBits + KeyBits;
  localparam int unsigned KeyLo  = NodeBits;
  localparam int unsigned NodeLo = NodeBits + KeyBits;

  // Request and working registers
  logic [NodeBits-1:0] node_q, nb_q;
  logic [KeyBits-1:0]  key_q;
  logic [EW-1:0]       mov_q, top_q, left_q;
  logic [SW-1:0]       idx_q, idx_d;
  logic [CW-1:0]       fill_q;
  logic [NW-1:0]       clr_q;
  status_e             res_q;

  // RAM ports
  logic [EW-1:0] heap_rd, heap_wdata;
  logic [SW-1:0] heap_raddr;
  logic          heap_we;
  logic [PW-1:0] pos_rd, pos_wdata;
  logic [NW-1:0] pos_raddr, pos_waddr;
  logic          pos_we;

  // Derived values
  logic [63:0]   key_in_x;
  logic [31:0]   node_in_x, wnode_x, tnode_x, fill_x;
  logic [CW:0]   idx_x, l_x, r_x, fill_w;
  logic [SW-1:0] parent, last, pos_slot;
  logic [KeyBits-1:0] key_in, rd_key, mov_key, left_key;
  logic [63:0]   okey_x;

  assign key_in_x  = 64'(cost_key_i);
  assign key_in    = key_in_x[KeyBits-1:0];
  assign node_in_x = 32'(node_id_i);
  assign idx_x     = (CW + 1)'(idx_q);
  assign l_x       = (idx_x << 1) + (CW + 1)'(1);
  assign r_x       = l_x + (CW + 1)'(1);
  assign fill_w    = (CW + 1)'(fill_q);
  assign parent    = (idx_q - SW'(1)) >> 1;
  assign last      = SW'(fill_q - CW'(1));
  assign pos_slot  = pos_rd[SW-1:0];
  assign rd_key    = heap_rd[KeyLo +: KeyBits];
  assign mov_key   = mov_q[KeyLo +: KeyBits];
  assign left_key  = left_q[KeyLo +: KeyBits];

  // Heap RAM read address
  always_comb begin
    unique case (cmd_i.hrd)
      HR_ROOT:   heap_raddr = '0;
      HR_LAST:   heap_raddr = last;
      HR_PARENT: heap_raddr = parent;
      HR_LEFT:   heap_raddr = l_x[SW-1:0];
      HR_RIGHT:  heap_raddr = r_x[SW-1:0];
      HR_POS:    heap_raddr = pos_slot;
      default:   heap_raddr = '0;
    endcase
  end

  // Heap write at the current slot; the position table follows the entry
  always_comb begin
    heap_we = 1'b1;
    unique case (cmd_i.hwr)
      HW_MOVING: heap_wdata = mov_q;
      HW_RDATA:  heap_wdata = heap_rd;
      HW_LEFT:   heap_wdata = left_q;
      default: begin
        heap_wdata = mov_q;
        heap_we    = 1'b0;
      end
    endcase
  end

  assign wnode_x   = 32'(heap_wdata[NodeLo +: NodeBits]);
  assign tnode_x   = 32'(top_q[NodeLo +: NodeBits]);
  assign pos_raddr = node_in_x[NW-1:0];

  always_comb begin
    pos_we    = 1'b1;
    pos_waddr = wnode_x[NW-1:0];
    pos_wdata = {1'b1, idx_q};
    priority if (cmd_i.clear_step) begin
      pos_waddr = clr_q;
      pos_wdata = '0;
    end else if (cmd_i.pos_clr_top) begin
      pos_waddr = tnode_x[NW-1:0];
      pos_wdata = '0;
    end else if (!heap_we) begin
      pos_we = 1'b0;
    end
  end

  imhdk_ram #(.Width(EW), .Depth(HeapCapacity)) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (heap_we),
    .waddr_i (idx_q),
    .wdata_i (heap_wdata),
    .raddr_i (heap_raddr),
    .rdata_o (heap_rd)
  );

  imhdk_ram #(.Width(PW), .Depth(NodeCount)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rd)
  );

  // Current slot update
  always_comb begin
    unique case (cmd_i.iop)
      IOP_HOLD:   idx_d = idx_q;
      IOP_FILL:   idx_d = SW'(fill_q);
      IOP_POS:    idx_d = pos_slot;
      IOP_ZERO:   idx_d = '0;
      IOP_PARENT: idx_d = parent;
      IOP_LEFT:   idx_d = l_x[SW-1:0];
      IOP_RIGHT:  idx_d = r_x[SW-1:0];
      default:    idx_d = idx_q;
    endcase
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.accept) begin
      node_q <= node_id_i;
      key_q  <= key_in;
      nb_q   <= neighbour_id_i;
    end
    if (cmd_i.load_top)    top_q  <= heap_rd;
    if (cmd_i.load_left)   left_q <= heap_rd;
    if (cmd_i.load_mov_rd) mov_q  <= heap_rd;
    if (cmd_i.load_mov_in) mov_q  <= {node_q, key_q, nb_q};
    if (cmd_i.res_set)     res_q  <= cmd_i.res_code;
  end

  // Control registers: fill count and clear sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      clr_q  <= '0;
    end else begin
      if (cmd_i.fill_inc) fill_q <= fill_q + CW'(1);
      if (cmd_i.fill_dec) fill_q <= fill_q - CW'(1);
      if (cmd_i.clear_step) clr_q <= clr_q + NW'(1);
    end
  end

  // Output register
  assign okey_x = 64'(top_q[KeyLo +: KeyBits]);
  assign fill_x = 32'(fill_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o      <= res_q;
      entry_count_o <= fill_x[CountBits-1:0];
      if (res_q == ST_EXTRACTED) begin
        out_node_o      <= top_q[NodeLo +: NodeBits];
        out_key_o       <= okey_x[InKeyBits-1:0];
        out_neighbour_o <= top_q[NodeBits-1:0];
      end else begin
        out_node_o      <= '0;
        out_key_o       <= '0;
        out_neighbour_o <= '0;
      end
    end
  end

  // Status to the controller
  always_comb begin
    sts_o.in_valid         = in_valid_i;
    sts_o.in_extract       = (opcode_i == OP_EXTRACT);
    sts_o.in_oob           = node_in_x >= 32'(NodeCount);
    sts_o.fill_zero        = (fill_q == '0);
    sts_o.fill_full        = (fill_q >= CW'(HeapCapacity));
    sts_o.fill_one         = (fill_q == CW'(1));
    sts_o.pos_valid        = pos_rd[SW];
    sts_o.pos_slot_ge_fill = CW'(pos_slot) >= fill_q;
    sts_o.in_lt_rd         = key_q < rd_key;
    sts_o.i_zero           = (idx_q == '0);
    sts_o.mov_lt_rd        = mov_key < rd_key;
    sts_o.mov_gt_rd        = mov_key > rd_key;
    sts_o.mov_gt_left      = mov_key > left_key;
    sts_o.left_lt_rd       = left_key < rd_key;
    sts_o.l_ge_fill        = l_x >= fill_w;
    sts_o.r_ge_fill        = r_x >= fill_w;
    sts_o.clear_done       = (clr_q == NW'(NodeCount - 1));
    sts_o.out_free         = !out_valid_o || out_ready_i;
  end

endmodule

`default_nettype wire

/* sv/indexed_min_heap_decrease_key.sv */
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key
// Indexed binary min-heap priority queue with decrease-key for path search.
// ----------------------------------------------------------------------------
// Requests arrive on in_i (valid/ready): opcode 0 inserts a node or lowers
// its key, opcode 1 removes the minimum entry. Each request gives exactly
// one result item on out_o with a status, the extracted entry (zero unless
// extracted) and the entry count after the operation.
// One request is in work at a time. A sift up compares with the parent at
// each level; a sift down reads the left child and, where one exists, the
// right child at each level.
// After reset the position table is cleared with in_i.ready low. The result
// sits in an output register; while out_o is stalled the block finishes the
// current request and waits before taking the next one.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_min_heap_decrease_key #(
  parameter int unsigned HEAP_CAPACITY = 1024,
  parameter int unsigned NODE_COUNT    = 4096,
  parameter int unsigned KEY_BITS      = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  imhdk_in_if.sink    in_i,
  imhdk_out_if.source out_o
);
  import imhdk_pkg::*;

  cmd_t cmd;
  sts_t sts;

  imhdk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_i.ready)
  );

  imhdk_dp #(
    .HeapCapacity (HEAP_CAPACITY),
    .NodeCount    (NODE_COUNT),
    .KeyBits      (KEY_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_valid_i      (in_i.valid),
    .opcode_i        (in_i.opcode),
    .node_id_i       (in_i.node_id),
    .cost_key_i      (in_i.cost_key),
    .neighbour_id_i  (in_i.neighbour_id),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .status_o        (out_o.status),
    .out_node_o      (out_o.out_node),
    .out_key_o       (out_o.out_key),
    .out_neighbour_o (out_o.out_neighbour),
    .entry_count_o   (out_o.entry_count)
  );

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the indexed min-heap with decrease-key: a local
// heap predictor works out each result; random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import imhdk_pkg::*;

  localparam int unsigned HeapCap = 1024;
  localparam int unsigned NodeCnt = 4096;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DeepFill = 150;

  typedef struct packed {
    logic [11:0] node;
    logic [31:0] key;
    logic [11:0] nb;
  } slot_t;

  typedef struct packed {
    status_e     status;
    logic [11:0] node;
    logic [31:0] key;
    logic [11:0] nb;
    logic [10:0] count;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  imhdk_in_if  req_if ();
  imhdk_out_if res_if ();

  indexed_min_heap_decrease_key dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if.sink),
    .out_o  (res_if.source)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predictor state
  slot_t       heap_q [HeapCap];
  logic [10:0] where_q [NodeCnt];
  bit          present_q [NodeCnt];
  int unsigned fill_q;
  outcome_t    pending_q [$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit          hold_off = 1'b0;

  function automatic void put_slot(int unsigned s, slot_t e);
    heap_q[s] = e;
    where_q[e.node] = s[10:0];
  endfunction

  function automatic void swap_slots(int unsigned a, int unsigned b);
    slot_t ea;
    slot_t eb;
    ea = heap_q[a];
    eb = heap_q[b];
    put_slot(a, eb);
    put_slot(b, ea);
  endfunction

  function automatic void heap_rise(int unsigned i);
    int unsigned p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (heap_q[i].key < heap_q[p].key) begin
        swap_slots(i, p);
        i = p;
      end else break;
    end
  endfunction

  function automatic void heap_sink(int unsigned i);
    int unsigned l;
    int unsigned r;
    int unsigned c;
    logic [31:0] k;
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      if (l >= fill_q) return;
      k = heap_q[i].key;
      if (r >= fill_q) begin
        if (k > heap_q[l].key) swap_slots(i, l);
        return;
      end
      if (k > heap_q[l].key || k > heap_q[r].key) begin
        c = (heap_q[l].key < heap_q[r].key) ? l : r;
        swap_slots(i, c);
        i = c;
      end else return;
    end
  endfunction

  function automatic outcome_t heap_predict(opcode_e op, logic [11:0] node,
                                            logic [31:0] key, logic [11:0] nb);
    outcome_t o;
    slot_t    top;
    slot_t    e;
    int unsigned s;
    o = '0;
    o.status = ST_UNCHANGED;
    if (op == OP_EXTRACT) begin
      if (fill_q == 0) o.status = ST_EMPTY;
      else begin
        top = heap_q[0];
        swap_slots(0, fill_q - 1);
        present_q[top.node] = 1'b0;
        fill_q--;
        heap_sink(0);
        o.status = ST_EXTRACTED;
        o.node = top.node;
        o.key = top.key;
        o.nb = top.nb;
      end
    end else if (!present_q[node]) begin
      if (fill_q >= HeapCap) o.status = ST_FULL;
      else begin
        e = '{node: node, key: key, nb: nb};
        s = fill_q;
        put_slot(s, e);
        present_q[node] = 1'b1;
        fill_q++;
        heap_rise(s);
        o.status = ST_INSERTED;
      end
    end else begin
      s = where_q[node];
      if (s < fill_q && key < heap_q[s].key) begin
        heap_q[s].key = key;
        heap_q[s].nb = nb;
        heap_rise(s);
        o.status = ST_DECREASED;
      end
    end
    o.count = fill_q[10:0];
    return o;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  // Random gap: mostly short, now and then long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one item, predicting its result at acceptance
  task automatic send_item(opcode_e op, logic [11:0] node, logic [31:0] key,
                           logic [11:0] nb);
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      req_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.opcode <= op;
    req_if.node_id <= node;
    req_if.cost_key <= key;
    req_if.neighbour_id <= nb;
    do @(posedge clk_i); while (!req_if.ready);
    pending_q.insert(pending_q.size(), heap_predict(op, node, key, nb));
  endtask

  // Receiver ready with random stalls and an occasional long hold-off
  initial begin
    int unsigned g;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        res_if.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      g = gap_len();
      if (g > 0) begin
        res_if.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    outcome_t w;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_q.size() == 0) report_mismatch("result with nothing expected");
      else begin
        w = pending_q.pop_front();
        if (res_if.status !== w.status)
          report_mismatch($sformatf("status %0d want %0d", res_if.status, w.status));
        if (res_if.out_node !== w.node)
          report_mismatch($sformatf("node %0d want %0d", res_if.out_node, w.node));
        if (res_if.out_key !== w.key)
          report_mismatch($sformatf("key %h want %h", res_if.out_key, w.key));
        if (res_if.out_neighbour !== w.nb)
          report_mismatch($sformatf("nb %0d want %0d", res_if.out_neighbour, w.nb));
        if (res_if.entry_count !== w.count)
          report_mismatch($sformatf("count %0d want %0d", res_if.entry_count, w.count));
      end
    end
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic test_edges();
    send_item(OP_EXTRACT, 12'd0, 32'd0, 12'd0);
    send_item(OP_INSERT, 12'd4095, 32'hFFFF_FFFF, 12'd4095);
    send_item(OP_INSERT, 12'd0, 32'd0, 12'd0);
    send_item(OP_INSERT, 12'd5, 32'd100, 12'd7);
    send_item(OP_INSERT, 12'd5, 32'd100, 12'd9);
    send_item(OP_INSERT, 12'd5, 32'd200, 12'd9);
    send_item(OP_INSERT, 12'd5, 32'd1, 12'hAAA);
    send_item(OP_INSERT, 12'd6, 32'd50, 12'h555);
    send_item(OP_INSERT, 12'd7, 32'd50, 12'h123);
    send_item(OP_INSERT, 12'd4095, 32'd2, 12'd1);
    repeat (8) send_item(OP_EXTRACT, 12'd0, 32'd0, 12'd0);
  endtask

  // Build a deep heap, then drain it and extract once more when empty
  task automatic test_deep();
    for (int i = 0; i < DeepFill; i++)
      send_item(OP_INSERT, 12'(i), $urandom_range(0, 255), 12'($urandom));
    send_item(OP_INSERT, 12'd2000, 32'd0, 12'd1);
    send_item(OP_INSERT, 12'd3, 32'd0, 12'd1);
    for (int i = 0; i <= DeepFill + 1; i++)
      send_item(OP_EXTRACT, 12'($urandom), 32'($urandom), 12'($urandom));
  endtask

  // Random mix, with a long receiver hold-off near the start
  task automatic test_random();
    int unsigned r;
    logic [31:0] k;
    for (int n = 0; n < 200; n++) begin
      if (n == 20) hold_off = 1'b1;
      r = $urandom_range(0, 99);
      k = (r[0]) ? 32'($urandom) : 32'($urandom_range(0, 63));
      if (r < 35)
        send_item(OP_EXTRACT, 12'($urandom), 32'($urandom), 12'($urandom));
      else if (r < 70)
        send_item(OP_INSERT, 12'($urandom_range(0, 31)), k, 12'($urandom));
      else
        send_item(OP_INSERT, 12'($urandom), k, 12'($urandom));
    end
  endtask

  initial begin
    int unsigned w;
    for (int i = 0; i < NodeCnt; i++) begin
      present_q[i] = 1'b0;
      where_q[i] = '0;
    end
    fill_q = 0;
    req_if.valid = 1'b0;
    req_if.opcode = 1'b0;
    req_if.node_id = '0;
    req_if.cost_key = '0;
    req_if.neighbour_id = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_edges();
    test_deep();
    test_random();
    req_if.valid <= 1'b0;
    w = 0;
    while (pending_q.size() != 0 && w < 100000) begin
      @(posedge clk_i);
      w++;
    end
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
sv/imhdk_pkg.sv
sv/imhdk_if.sv
sv/imhdk_ram.sv
sv/imhdk_ctrl.sv
sv/imhdk_dp.sv
sv/indexed_min_heap_decrease_key.sv
bench/tb_top.sv
